FILE: src/sdcc_pkg.sv
// Shared types and constants for the SLIP deframer with checksum check.
// Used by the output queue and by the top level; depends on nothing else.
`default_nettype none

package sdcc_pkg;

	localparam logic [7:0] SLIP_END     = 8'hC0;
	localparam logic [7:0] SLIP_ESC     = 8'hDB;
	localparam logic [7:0] SLIP_ESC_END = 8'hDC;
	localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;
	localparam logic [7:0] CHECK_INVERT = 8'hFF;

	// Raw bytes allowed in one frame before it is cut off as an overflow.
	localparam int MAX_RAW_BYTES = 256;
	localparam int CNT_W         = 9;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SHORT    = 2'd1,
		ST_BAD_SUM  = 2'd2,
		ST_OVERFLOW = 2'd3
	} frame_status_t;

	typedef struct packed {
		logic [7:0]       data_byte;
		logic             is_end;
		frame_status_t    frame_status;
		logic [CNT_W-1:0] frame_length;
	} result_t;

	// Which of the two write slots of the queue carry a result this cycle.
	typedef struct packed {
		logic push_a;
		logic push_b;
	} push_t;

endpackage

`default_nettype wire

FILE: src/slip_deframer_checksum_check_unit.sv
// Top level of the SLIP deframer with folded-sum checksum check.
// Holds the frame state and decode logic; uses sdcc_pkg and sdcc_outq.
// Each result is registered in the output queue before it can be transferred.
// Throughput: one input byte per cycle while the output side keeps up; the
// four-entry result queue stalls the input once more than two results wait.
// Reset: arst_n clears the frame state and empties the queue at once.
`default_nettype none

module slip_deframer_checksum_check_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [7:0]                rx_byte,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [7:0]                     data_byte,
	output logic                           is_end,
	output logic [1:0]                     frame_status,
	output logic [sdcc_pkg::CNT_W-1:0]     frame_length
);
	import sdcc_pkg::*;

	// Frame state. The decoded bytes run one byte late through held_byte_q,
	// so that the last byte of a frame, the checksum, is never passed on as
	// data. running_sum_q is the sum of the bytes already passed on.
	logic             escape_q;
	logic [CNT_W-1:0] raw_count_q;
	logic [CNT_W-1:0] decoded_count_q;
	logic [15:0]      running_sum_q;
	logic [7:0]       held_byte_q;
	logic             held_valid_q;

	logic             escape_d;
	logic [CNT_W-1:0] raw_count_d;
	logic [CNT_W-1:0] decoded_count_d;
	logic [15:0]      running_sum_d;
	logic [7:0]       held_byte_d;
	logic             held_valid_d;

	logic             accept;
	logic             room_two;
	push_t            push;
	result_t          item_a;
	result_t          item_b;
	result_t          out_item;
	logic [15:0]      sum_pushed;

	// The input is held off whenever the queue could not absorb the two
	// results that a single byte may cause.
	assign in_stall   = !room_two;
	assign accept     = in_valid && !in_stall;
	assign sum_pushed = running_sum_q + {8'h00, held_byte_q};

	always_comb begin
		logic [15:0]      end_sum;
		logic [7:0]       end_held;
		logic [CNT_W-1:0] end_count;
		logic [7:0]       check;
		logic [7:0]       decoded;
		frame_status_t    status;
		result_t          end_item;
		result_t          held_item;

		escape_d        = escape_q;
		raw_count_d     = raw_count_q;
		decoded_count_d = decoded_count_q;
		running_sum_d   = running_sum_q;
		held_byte_d     = held_byte_q;
		held_valid_d    = held_valid_q;
		push            = '0;
		item_a          = '0;
		item_b          = '0;

		end_sum   = running_sum_q;
		end_held  = held_byte_q;
		end_count = decoded_count_q;
		decoded   = rx_byte;
		status    = ST_OK;

		held_item           = '0;
		held_item.data_byte = held_byte_q;

		if (escape_q) begin
			// An escape still open at the frame end stands for a literal
			// escape byte, which pushes the held byte out first.
			end_held  = SLIP_ESC;
			end_count = decoded_count_q + CNT_W'(1);
			if (held_valid_q) begin
				end_sum = sum_pushed;
			end
		end
		check = (end_sum[7:0] + end_sum[15:8]) ^ CHECK_INVERT;
		if (end_count < CNT_W'(3)) begin
			status = ST_SHORT;
		end else if (check != end_held) begin
			status = ST_BAD_SUM;
		end

		end_item              = '0;
		end_item.is_end       = 1'b1;
		end_item.frame_status = status;
		end_item.frame_length = end_count;

		if (escape_q) begin
			case (rx_byte)
				SLIP_ESC_END: decoded = SLIP_END;
				SLIP_ESC_ESC: decoded = SLIP_ESC;
				default:      decoded = rx_byte;
			endcase
		end

		if (accept) begin
			if (rx_byte == SLIP_END) begin
				if (raw_count_q != '0) begin
					if (escape_q && held_valid_q) begin
						push.push_a = 1'b1;
						push.push_b = 1'b1;
						item_a      = held_item;
						item_b      = end_item;
					end else begin
						push.push_a = 1'b1;
						item_a      = end_item;
					end
				end
				escape_d        = 1'b0;
				raw_count_d     = '0;
				decoded_count_d = '0;
				running_sum_d   = '0;
				held_byte_d     = '0;
				held_valid_d    = 1'b0;
			end else if (raw_count_q >= CNT_W'(MAX_RAW_BYTES)) begin
				// Frame too long: report it and start afresh; this byte is lost.
				push.push_a           = 1'b1;
				item_a                = '0;
				item_a.is_end         = 1'b1;
				item_a.frame_status   = ST_OVERFLOW;
				item_a.frame_length   = decoded_count_q;
				escape_d              = 1'b0;
				raw_count_d           = '0;
				decoded_count_d       = '0;
				running_sum_d         = '0;
				held_byte_d           = '0;
				held_valid_d          = 1'b0;
			end else begin
				raw_count_d = raw_count_q + CNT_W'(1);
				if (!escape_q && rx_byte == SLIP_ESC) begin
					escape_d = 1'b1;
				end else begin
					escape_d = 1'b0;
					if (held_valid_q) begin
						push.push_a   = 1'b1;
						item_a        = held_item;
						running_sum_d = sum_pushed;
					end
					held_byte_d     = decoded;
					held_valid_d    = 1'b1;
					decoded_count_d = decoded_count_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q        <= 1'b0;
			raw_count_q     <= '0;
			decoded_count_q <= '0;
			running_sum_q   <= '0;
			held_byte_q     <= '0;
			held_valid_q    <= 1'b0;
		end else begin
			escape_q        <= escape_d;
			raw_count_q     <= raw_count_d;
			decoded_count_q <= decoded_count_d;
			running_sum_q   <= running_sum_d;
			held_byte_q     <= held_byte_d;
			held_valid_q    <= held_valid_d;
		end
	end

	// Results wait in a short queue, so that the output side may stall
	// without holding up a byte that has already been taken.
	sdcc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item_a    (item_a),
		.item_b    (item_b),
		.room_two  (room_two),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	assign data_byte    = out_item.data_byte;
	assign is_end       = out_item.is_end;
	assign frame_status = out_item.frame_status;
	assign frame_length = out_item.frame_length;

	// An end byte with nothing gathered since the last end gives no result.
	a_empty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && rx_byte == SLIP_END && raw_count_q == '0) |-> !push.push_a)
		else $error("empty frame produced a result");

	// The decoded count never runs ahead of the raw count.
	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		decoded_count_q <= raw_count_q)
		else $error("decoded count exceeds raw count");

	// The held byte is valid exactly when at least one byte was decoded.
	a_held_track: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q == (decoded_count_q != '0))
		else $error("held byte flag out of step with decoded count");

	// After a frame end the raw count, held flag, escape flag and running sum are back at reset.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && rx_byte == SLIP_END) |=>
		(raw_count_q == '0 && !held_valid_q && !escape_q && running_sum_q == '0))
		else $error("frame state not cleared at frame end");

endmodule

`default_nettype wire

FILE: src/sdcc_outq.sv
// Flip-flop result queue: up to two results in a cycle, one out unless stalled.
// Depends on sdcc_pkg for the result type and the queue depth.
`default_nettype none

module sdcc_outq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sdcc_pkg::push_t  push,
	input  wire sdcc_pkg::result_t item_a,
	input  wire sdcc_pkg::result_t item_b,
	output logic                  room_two,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output sdcc_pkg::result_t     out_item
);
	import sdcc_pkg::*;

	result_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                pop;
	logic [QPTR_W-1:0]   wr_ptr_b;
	logic [QCNT_W-1:0]   n_push;

	assign out_valid = (count_q != '0);
	assign out_item  = entry_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;
	assign room_two  = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));
	assign wr_ptr_b  = wr_ptr_q + QPTR_W'(1);
	assign n_push    = QCNT_W'(push.push_a) + QCNT_W'(push.push_b);

	always_ff @(posedge clk) begin
		if (push.push_a) begin
			entry_q[wr_ptr_q] <= item_a;
		end
		if (push.push_b) begin
			entry_q[wr_ptr_b] <= item_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			wr_ptr_q <= wr_ptr_q + QPTR_W'(n_push);
			count_q  <= count_q + n_push - QCNT_W'(pop);
		end
	end

	// The second slot is only ever used together with the first.
	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.push_b |-> push.push_a)
		else $error("queue slot b written without slot a");

	// The fill level never exceeds the number of entries.
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("result queue overfilled");

	// Fill level follows pushes and pops exactly.
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q == $past(count_q) + $past(n_push) - QCNT_W'($past(pop)))
		else $error("result queue count out of step");

endmodule

`default_nettype wire
